/* hdl/psd_pkg.sv */
// Shared definitions for the pulse burst settle detector.
// Holds default sizes, field widths, codes and the queue status type.
// No dependencies; every other file in hdl refers to it by scoped names.
package psd_pkg;

   localparam int NUM_CHANNELS_DEF = 3;
   localparam int TIME_WIDTH_DEF   = 16;
   localparam int SETTLE_W         = 16;
   localparam int COUNT_W          = 32;
   localparam int PINS_W           = 3;
   localparam int CHAN_W           = 2;
   localparam int QUEUE_DEPTH      = 4;
   localparam int RSP_DATA_W       = ((CHAN_W + COUNT_W + 7) / 8) * 8;

   localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1500;

   typedef enum logic {
      CMD_EDGE = 1'b0,
      CMD_TICK = 1'b1
   } command_type;

   typedef enum logic {
      EVT_JITTER  = 1'b0,
      EVT_SETTLED = 1'b1
   } event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* hdl/psd_front.sv */
// Front end: holds the settle period and the per-channel count, armed flag
// and deadline, and turns each tick into one bundle of reports.
// Depends on psd_pkg.
module psd_front #(
   parameter int NUM_CHANNELS = psd_pkg::NUM_CHANNELS_DEF,
   parameter int TIME_WIDTH   = psd_pkg::TIME_WIDTH_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         csr_we,
   input  logic [psd_pkg::SETTLE_W-1:0]                 csr_wdata,
   input  logic                                         item_take,
   input  logic                                         item_command,
   input  logic [psd_pkg::CHAN_W-1:0]                   item_channel,
   input  logic [TIME_WIDTH-1:0]                        item_now,
   input  logic [psd_pkg::PINS_W-1:0]                   item_pins,
   output logic                                         rpt_push,
   output logic [NUM_CHANNELS-1:0]                      rpt_valid,
   output logic [NUM_CHANNELS-1:0]                      rpt_kind,
   output logic [NUM_CHANNELS-1:0][psd_pkg::COUNT_W-1:0] rpt_count
);

   logic [psd_pkg::SETTLE_W-1:0] settle_ff, settle_in;
   logic                         is_tick, is_edge;
   logic [TIME_WIDTH-1:0]        next_deadline;

   always_comb begin
      settle_in = csr_we ? csr_wdata : settle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= psd_pkg::SETTLE_RESET;
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign is_tick       = item_take && (item_command == psd_pkg::CMD_TICK);
   assign is_edge       = item_take && (item_command == psd_pkg::CMD_EDGE);
   assign next_deadline = item_now + TIME_WIDTH'(settle_ff);

   // Only a tick that produced at least one report goes into the queue.
   assign rpt_push = is_tick && (rpt_valid != '0);

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
      logic                        armed_ff, armed_in;
      logic [TIME_WIDTH-1:0]       deadline_ff, deadline_in;
      logic [psd_pkg::COUNT_W-1:0] count_ff, count_in;
      logic                        pin_low, chan_match, hit, lane_valid;
      psd_pkg::event_type          lane_kind;

      // Only the channels that have a pin sense can report a settle.
      if (i < psd_pkg::PINS_W) begin : g_pin
         assign pin_low = item_pins[i];
      end else begin : g_nopin
         assign pin_low = 1'b0;
      end

      assign chan_match = (int'(item_channel) == i);
      assign hit        = is_tick && armed_ff && (deadline_ff == item_now);

      always_comb begin
         armed_in    = armed_ff;
         deadline_in = deadline_ff;
         count_in    = count_ff;
         lane_valid  = 1'b0;
         lane_kind   = psd_pkg::EVT_JITTER;
         if (hit) begin
            count_in = '0;
            if (count_ff != '0) begin
               deadline_in = next_deadline;
               lane_valid  = 1'b1;
            end else begin
               armed_in   = 1'b0;
               lane_valid = pin_low;
               lane_kind  = psd_pkg::EVT_SETTLED;
            end
         end else if (is_edge && chan_match) begin
            if (count_ff != '1) begin
               count_in = count_ff + psd_pkg::COUNT_W'(1);
            end
            if (!armed_ff) begin
               armed_in    = 1'b1;
               deadline_in = next_deadline;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            armed_ff    <= 1'b0;
            deadline_ff <= '0;
            count_ff    <= '0;
         end else begin
            armed_ff    <= armed_in;
            deadline_ff <= deadline_in;
            count_ff    <= count_in;
         end
      end

      // A settle report reads a count that is already zero.
      assign rpt_valid[i] = lane_valid;
      assign rpt_kind[i]  = lane_kind;
      assign rpt_count[i] = count_ff;
   end

endmodule

/* hdl/psd_queue.sv */
// Short queue of report bundles between the front and the back end.
// Plain circular buffer with a fill count; depends on psd_pkg.
module psd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = psd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   din,
   input  logic               pop,
   output logic [WIDTH-1:0]   dout,
   output psd_pkg::qstat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout       = entries_ff[rd_ptr_ff];
   assign stat.full  = (fill_ff == CNT_W'(DEPTH));
   assign stat.empty = (fill_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full) else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty) else $error("queue read while empty");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH)) else $error("queue fill count out of range");

endmodule

/* hdl/psd_back.sv */
// Back end: takes one report bundle at a time from the queue and hands its
// reports out one beat each, lowest channel first. Depends on psd_pkg.
module psd_back #(
   parameter int NUM_CHANNELS = psd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         q_empty,
   input  logic [NUM_CHANNELS-1:0]                      head_valid,
   input  logic [NUM_CHANNELS-1:0]                      head_kind,
   input  logic [NUM_CHANNELS-1:0][psd_pkg::COUNT_W-1:0] head_count,
   output logic                                         q_pop,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic                                         rsp_kind,
   output logic [psd_pkg::CHAN_W-1:0]                   rsp_channel,
   output logic [psd_pkg::COUNT_W-1:0]                  rsp_count,
   output logic                                         rsp_last
);

   localparam int SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [NUM_CHANNELS-1:0]                       pend_ff, pend_in, pend_after;
   logic [NUM_CHANNELS-1:0]                       kind_ff, kind_in;
   logic [NUM_CHANNELS-1:0][psd_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_CHANNELS-1:0]                       low, rest;
   logic [SEL_W-1:0]                              sel;
   logic                                          fire;

   // Isolate the lowest pending channel.
   assign low  = pend_ff & (~pend_ff + NUM_CHANNELS'(1));
   assign rest = pend_ff & ~low;

   always_comb begin
      sel = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (low[i]) begin
            sel = SEL_W'(i);
         end
      end
   end

   assign rsp_tvalid  = (pend_ff != '0);
   assign fire        = rsp_tvalid && rsp_tready;
   assign rsp_kind    = kind_ff[sel];
   assign rsp_channel = psd_pkg::CHAN_W'(sel);
   assign rsp_count   = cnt_ff[sel];
   assign rsp_last    = (rest == '0);

   assign pend_after = fire ? rest : pend_ff;
   // The next bundle is loaded in the cycle the last beat of this one leaves.
   assign q_pop      = (pend_after == '0) && !q_empty;

   always_comb begin
      pend_in = pend_after;
      kind_in = kind_ff;
      cnt_in  = cnt_ff;
      if (q_pop) begin
         pend_in = head_valid;
         kind_in = head_kind;
         cnt_in  = head_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      cnt_ff  <= cnt_in;
   end

   a_no_idle_gap: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !q_empty |=> rsp_tvalid)
      else $error("queued reports left waiting");

   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      fire && !rsp_last |=> rsp_tvalid)
      else $error("report burst broken before its last beat");

   a_settle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_kind == psd_pkg::EVT_SETTLED) |-> (rsp_count == '0))
      else $error("settled report carries a nonzero count");

endmodule

/* hdl/pulse_burst_settle_detector_top.sv */
// Top level of the pulse burst settle detector: front end, report queue and
// back end. Depends on psd_pkg, psd_front, psd_queue and psd_back.
//
//   port group  direction  handshake              tdata / tuser / tlast
//   req_        in         req_tvalid/req_tready  channel, now_time, pins_low / command
//   rsp_        out        rsp_tvalid/rsp_tready  report_channel, pulse_count
//                                                 / event_kind / last_report
//   csr_        in         csr_we                 settle_period
//
// One item is accepted per clock while the report queue has a free slot.
// A tick's reports leave one beat per cycle while rsp_tready is high, once their bundle has
// passed the queue into the back end. A tick with k reports holds the back end until all k
// leave; the QUEUE_DEPTH-entry queue absorbs such bursts until it fills and req_tready drops.
// Reset is synchronous and clears all channel state; the settle period returns to 1500.
module pulse_burst_settle_detector_top #(
   parameter int NUM_CHANNELS = psd_pkg::NUM_CHANNELS_DEF,
   parameter int TIME_WIDTH   = psd_pkg::TIME_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [psd_pkg::SETTLE_W-1:0]           csr_wdata,   // settle_period
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // channel, now_time, pins_low, zero padding
   input  logic [((TIME_WIDTH + 12) / 8) * 8-1:0] req_tdata,
   input  logic                                   req_tuser,   // command
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // report_channel, pulse_count, zero padding
   output logic [psd_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tuser,   // event_kind
   output logic                                   rsp_tlast    // last_report
);

   localparam int ENTRY_W = NUM_CHANNELS * (psd_pkg::COUNT_W + 2);
   localparam int NOW_LO  = psd_pkg::CHAN_W;
   localparam int PINS_LO = NOW_LO + TIME_WIDTH;
   localparam int PAD_W   = psd_pkg::RSP_DATA_W - psd_pkg::CHAN_W - psd_pkg::COUNT_W;

   logic                                          take;
   logic                                          rpt_push, q_pop;
   logic [NUM_CHANNELS-1:0]                       rpt_valid, rpt_kind;
   logic [NUM_CHANNELS-1:0][psd_pkg::COUNT_W-1:0] rpt_count;
   logic [NUM_CHANNELS-1:0]                       head_valid, head_kind;
   logic [NUM_CHANNELS-1:0][psd_pkg::COUNT_W-1:0] head_count;
   logic [ENTRY_W-1:0]                            q_dout;
   psd_pkg::qstat_type                            q_stat;
   logic [psd_pkg::CHAN_W-1:0]                    rsp_channel;
   logic [psd_pkg::COUNT_W-1:0]                   rsp_count;

   assign req_tready = !q_stat.full;
   assign take       = req_tvalid && req_tready;

   psd_front #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TIME_WIDTH   (TIME_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .item_take    (take),
      .item_command (req_tuser),
      .item_channel (req_tdata[psd_pkg::CHAN_W-1:0]),
      .item_now     (req_tdata[PINS_LO-1:NOW_LO]),
      .item_pins    (req_tdata[PINS_LO+psd_pkg::PINS_W-1:PINS_LO]),
      .rpt_push     (rpt_push),
      .rpt_valid    (rpt_valid),
      .rpt_kind     (rpt_kind),
      .rpt_count    (rpt_count)
   );

   psd_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (psd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (rpt_push),
      .din   ({rpt_count, rpt_kind, rpt_valid}),
      .pop   (q_pop),
      .dout  (q_dout),
      .stat  (q_stat)
   );

   assign {head_count, head_kind, head_valid} = q_dout;

   psd_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_stat.empty),
      .head_valid  (head_valid),
      .head_kind   (head_kind),
      .head_count  (head_count),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_channel (rsp_channel),
      .rsp_count   (rsp_count),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_count, rsp_channel};

endmodule
